[hw/rtl/lru_page_replacement_core_macros.svh]
// Assertion helpers for the checker file of this block.
`ifndef LRU_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_CORE_MACROS_SVH

// Clocked assertion, held off while reset is active.
`define LRUPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion that only checks while a result is offered on the output.
`define LRUPR_ASSERT_OUT(label, prop, msg) \
  `LRUPR_ASSERT(label, out_valid_o |-> (prop), msg)

`endif

[hw/rtl/lrupr_pkg.sv]
`timescale 1ns / 1ps

package lrupr_pkg;

  // Fixed field widths of the transaction payloads
  localparam int PAGE_W  = 16;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 4;
  localparam int IDX_W   = 3;

  localparam logic [COUNT_W-1:0] FAULT_MAX   = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0]   FRAMES_RST  = 4'd8;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              end_of_string;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_total;
  } out_item_t;

endpackage

[hw/rtl/lru_page_replacement_core.sv]
`timescale 1ns / 1ps

// LRU page replacement core. Each page reference returns one result: hit or
// fault, the frame now holding the page, the evicted page if any, and the
// saturating fault count of the current string. Up to two references queue
// in front of the engine, so the input keeps accepting while one is worked
// on and a result waits in the output register. For each item the engine
// walks the active frames of the page/age memory one frame per cycle twice,
// once to look the page up and once to update recency ranks. Writing the
// frame count register clears all frames and the fault count; write it only
// while no reference is in flight.
module lru_page_replacement_core #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lrupr_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lrupr_pkg::in_item_t            in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lrupr_pkg::out_item_t           out_item_o
);

  localparam int LW = $clog2(FRAMES + 1);
  localparam int XW = LW + lrupr_pkg::CFG_W;

  logic [lrupr_pkg::CFG_W-1:0] frames_in_use_q;
  logic [XW-1:0]               fiu_ext;
  logic [LW-1:0]               limit;
  logic                        cfg_write;
  logic                        q_valid, q_pop;
  lrupr_pkg::in_item_t         q_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // frame count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= lrupr_pkg::FRAMES_RST;
    end else if (cfg_write) begin
      frames_in_use_q <= cfg_data_i;
    end
  end

  // clamp the active frame count to 1..FRAMES
  always_comb begin
    fiu_ext = XW'(frames_in_use_q);
    if (fiu_ext == '0) begin
      limit = LW'(1);
    end else if (fiu_ext > XW'(FRAMES)) begin
      limit = LW'(FRAMES);
    end else begin
      limit = LW'(frames_in_use_q);
    end
  end

  lrupr_front #(
    .PAGE_BITS (PAGE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  lrupr_back #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit),
    .clear_i     (cfg_write),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hw/rtl/lrupr_front.sv]
`timescale 1ns / 1ps

// Front end: takes references, trims the page to its live width and
// parks them in a two-entry queue for the replacement engine.
module lrupr_front #(
  parameter int PAGE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lrupr_pkg::in_item_t in_item_i,
  output logic                q_valid_o,
  output lrupr_pkg::in_item_t q_item_o,
  input  logic                q_pop_i
);

  localparam int DEPTH = 2;
  localparam logic [lrupr_pkg::PAGE_W-1:0] PAGE_MASK =
    (PAGE_BITS >= lrupr_pkg::PAGE_W) ? {lrupr_pkg::PAGE_W{1'b1}} :
    lrupr_pkg::PAGE_W'((64'd1 << PAGE_BITS) - 64'd1);

  lrupr_pkg::in_item_t entry_q [DEPTH];
  lrupr_pkg::in_item_t push_item;
  logic                wptr_q, rptr_q;
  logic [1:0]          cnt_q;
  logic                push;

  // classify: only the low page bits take part in matching
  always_comb begin
    push_item             = in_item_i;
    push_item.page_number = in_item_i.page_number & PAGE_MASK;
  end

  assign in_stall_o = (cnt_q == 2'(DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = entry_q[rptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (q_pop_i) rptr_q <= ~rptr_q;
      case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[hw/rtl/lrupr_back.sv]
`timescale 1ns / 1ps

// Replacement engine: one frame per cycle through the page/age memory,
// first a lookup sweep, then a recency update sweep.
module lrupr_back #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16,
  parameter int IW        = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  parameter int LW        = $clog2(FRAMES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [LW-1:0]        limit_i,
  input  logic                 clear_i,
  input  logic                 q_valid_i,
  input  lrupr_pkg::in_item_t  q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lrupr_pkg::out_item_t out_item_o
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DEC, S_UPD, S_OUT} state_e;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [IW-1:0]        age;
  } entry_t;

  state_e               state_q;
  entry_t               mem_q [FRAMES];
  entry_t               rdata_q;
  logic                 rvalid_q;
  logic [IW-1:0]        ridx_q;
  logic [LW-1:0]        rd_cnt_q;
  logic                 rd_issue;
  logic                 rd_last;

  logic [FRAMES-1:0]    valid_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 eos_q;
  logic [lrupr_pkg::COUNT_W-1:0] fault_q;

  // lookup sweep results
  logic                 hit_q, free_q;
  logic [IW-1:0]        hit_idx_q, free_idx_q, best_idx_q;
  logic [IW-1:0]        hit_age_q, best_age_q;
  logic [PAGE_BITS-1:0] best_page_q;

  // decision
  logic [IW-1:0]        f_q, old_q;
  logic                 inc_all_q;
  lrupr_pkg::out_item_t res_q, out_q;
  logic                 out_valid_q;

  // update sweep write port
  logic                 upd_we;
  entry_t               upd_wdata;
  logic                 cur_valid;

  assign rd_issue  = ((state_q == S_SCAN) || (state_q == S_UPD)) && (rd_cnt_q < limit_i);
  assign rd_last   = rvalid_q && (LW'(ridx_q) == (limit_i - LW'(1)));
  assign cur_valid = valid_q[ridx_q];
  assign q_pop_o   = (state_q == S_IDLE) && q_valid_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // recency update for the entry just read
  always_comb begin
    upd_we    = 1'b0;
    upd_wdata = rdata_q;
    if (state_q == S_UPD && rvalid_q) begin
      if (ridx_q == f_q) begin
        upd_we         = 1'b1;
        upd_wdata.page = page_q;
        upd_wdata.age  = '0;
      end else if (cur_valid && (inc_all_q || rdata_q.age < old_q)) begin
        upd_we        = 1'b1;
        upd_wdata.age = rdata_q.age + IW'(1);
      end
    end
  end

  // page/age memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      mem_q[ridx_q] <= upd_wdata;
    end
    if (rd_issue) begin
      rdata_q <= mem_q[rd_cnt_q[IW-1:0]];
    end
    ridx_q <= rd_cnt_q[IW-1:0];
  end

  // control sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rvalid_q    <= 1'b0;
      rd_cnt_q    <= '0;
      valid_q     <= '0;
      fault_q     <= '0;
      page_q      <= '0;
      eos_q       <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      hit_idx_q   <= '0;
      free_idx_q  <= '0;
      best_idx_q  <= '0;
      hit_age_q   <= '0;
      best_age_q  <= '0;
      best_page_q <= '0;
      f_q         <= '0;
      old_q       <= '0;
      inc_all_q   <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rvalid_q <= rd_issue;
      if (rd_issue) rd_cnt_q <= rd_cnt_q + LW'(1);

      // result taken; S_OUT refills the register itself
      if (out_valid_q && !out_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            page_q   <= PAGE_BITS'(q_item_i.page_number);
            eos_q    <= q_item_i.end_of_string;
            hit_q    <= 1'b0;
            free_q   <= 1'b0;
            rd_cnt_q <= '0;
            state_q  <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (rvalid_q) begin
            if (!hit_q && cur_valid && rdata_q.page == page_q) begin
              hit_q     <= 1'b1;
              hit_idx_q <= ridx_q;
              hit_age_q <= rdata_q.age;
            end
            if (!free_q && !cur_valid) begin
              free_q     <= 1'b1;
              free_idx_q <= ridx_q;
            end
            if (ridx_q == '0 || rdata_q.age > best_age_q) begin
              best_idx_q  <= ridx_q;
              best_age_q  <= rdata_q.age;
              best_page_q <= rdata_q.page;
            end
            if (rd_last) state_q <= S_DEC;
          end
        end

        S_DEC: begin
          // hit, else lowest free frame, else least recent frame
          f_q       <= hit_q ? hit_idx_q : (free_q ? free_idx_q : best_idx_q);
          old_q     <= hit_q ? hit_age_q : best_age_q;
          inc_all_q <= !hit_q && free_q;
          res_q.hit           <= hit_q;
          res_q.frame_index   <= lrupr_pkg::IDX_W'(hit_q ? hit_idx_q :
                                  (free_q ? free_idx_q : best_idx_q));
          res_q.evicted_valid <= !hit_q && !free_q;
          res_q.evicted_page  <= (!hit_q && !free_q) ?
                                  lrupr_pkg::PAGE_W'(best_page_q) : '0;
          if (!hit_q && fault_q != lrupr_pkg::FAULT_MAX) begin
            res_q.fault_total <= fault_q + lrupr_pkg::COUNT_W'(1);
            fault_q           <= fault_q + lrupr_pkg::COUNT_W'(1);
          end else begin
            res_q.fault_total <= fault_q;
          end
          rd_cnt_q <= '0;
          state_q  <= S_UPD;
        end

        S_UPD: begin
          if (rd_last) begin
            valid_q[f_q] <= 1'b1;
            state_q      <= S_OUT;
          end
        end

        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            if (eos_q) begin
              valid_q <= '0;
              fault_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase

      // register write starts a fresh string
      if (clear_i) begin
        valid_q <= '0;
        fault_q <= '0;
      end
    end
  end

endmodule

[hw/rtl/lrupr_checker.sv]
`timescale 1ns / 1ps
`include "lru_page_replacement_core_macros.svh"

// Port-level checks on the result channel.
module lrupr_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input lrupr_pkg::out_item_t out_item_o
);

  // a stalled result stays offered
  `LRUPR_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")

  // a replacement only happens on a fault
  `LRUPR_ASSERT_OUT(a_evict_on_fault, !(out_item_o.hit && out_item_o.evicted_valid), "eviction on hit")

  // without an eviction the evicted page reads zero
  `LRUPR_ASSERT_OUT(a_evict_zero, out_item_o.evicted_valid || out_item_o.evicted_page == '0, "stray evicted page")

  // a fault is always counted
  `LRUPR_ASSERT_OUT(a_fault_count, out_item_o.hit || out_item_o.fault_total != '0, "fault not counted")

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (.*);

[dv/tb_lru_page_replacement_core.sv]
`timescale 1ns / 1ps

module tb_lru_page_replacement_core;

  localparam int NUM_FRAMES  = 8;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int MAX_GAP     = 11;
  localparam int SETTLE_CYC  = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [lrupr_pkg::CFG_W-1:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  lrupr_pkg::in_item_t  in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  lrupr_pkg::out_item_t out_item_o;

  lru_page_replacement_core #(
    .FRAMES    (NUM_FRAMES),
    .PAGE_BITS (lrupr_pkg::PAGE_W)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Clock
  always #1 clk_i = ~clk_i;

  // Shadow LRU state
  logic [lrupr_pkg::PAGE_W-1:0]  frm_page  [NUM_FRAMES];
  bit                            frm_valid [NUM_FRAMES];
  int unsigned                   frm_rank  [NUM_FRAMES];  // 0 = most recent
  logic [lrupr_pkg::COUNT_W-1:0] fault_cnt;
  logic [lrupr_pkg::CFG_W-1:0]   frames_reg;

  lrupr_pkg::out_item_t pending_results[$];
  int        mismatches = 0;
  int        cycle_cnt  = 0;
  bit        tx_gaps    = 1'b1;
  bit        rx_gaps    = 1'b1;
  int        hold_cycles = 0;

  function automatic void clear_frames();
    for (int i = 0; i < NUM_FRAMES; i++) begin
      frm_page[i]  = '0;
      frm_valid[i] = 1'b0;
      frm_rank[i]  = 0;
    end
    fault_cnt = '0;
  endfunction

  // Make frame f most recent; frames ranked ahead of its old position age by one
  function automatic void promote(int f, int lim, bit was_valid);
    int unsigned old;
    old = was_valid ? frm_rank[f] : 32'hFFFF_FFFF;
    for (int i = 0; i < lim; i++) begin
      if (i != f && frm_valid[i] && frm_rank[i] < old) frm_rank[i]++;
    end
    frm_rank[f] = 0;
  endfunction

  // Apply one page reference to the shadow state and return the expected result
  function automatic lrupr_pkg::out_item_t lru_reference(lrupr_pkg::in_item_t ref_item);
    lrupr_pkg::out_item_t r;
    int        lim;
    int        f;
    int        best;
    bit        hit;
    bit        found;
    r     = '0;
    f     = 0;
    hit   = 1'b0;
    found = 1'b0;
    // zero acts as one frame, values past the array size act as all frames
    if (frames_reg == 0) lim = 1;
    else if (frames_reg > NUM_FRAMES) lim = NUM_FRAMES;
    else lim = frames_reg;

    for (int i = 0; i < lim; i++) begin
      if (!hit && frm_valid[i] && frm_page[i] == ref_item.page_number) begin
        f   = i;
        hit = 1'b1;
      end
    end

    if (hit) begin
      promote(f, lim, 1'b1);
    end else begin
      for (int i = 0; i < lim; i++) begin
        if (!found && !frm_valid[i]) begin
          f     = i;
          found = 1'b1;
        end
      end
      if (found) begin
        promote(f, lim, 1'b0);
      end else begin
        best = 0;
        for (int i = 1; i < lim; i++) begin
          if (frm_rank[i] > frm_rank[best]) best = i;
        end
        f               = best;
        r.evicted_valid = 1'b1;
        r.evicted_page  = frm_page[f];
        promote(f, lim, 1'b1);
      end
      frm_page[f]  = ref_item.page_number;
      frm_valid[f] = 1'b1;
      if (fault_cnt != lrupr_pkg::FAULT_MAX) fault_cnt++;
    end

    r.hit         = hit;
    r.frame_index = lrupr_pkg::IDX_W'(f);
    r.fault_total = fault_cnt;
    if (ref_item.end_of_string) clear_frames();
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Send one page reference; predict on acceptance
  task automatic send_ref(logic [lrupr_pkg::PAGE_W-1:0] page, bit eos);
    int gap;
    gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i              = 1'b1;
    in_item_i.page_number   = page;
    in_item_i.end_of_string = eos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(lru_reference(in_item_i));
  endtask

  // Stop sending and wait until every expected result has been taken
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_frames(logic [lrupr_pkg::CFG_W-1:0] value);
    wait_drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    frames_reg = value;
    clear_frames();
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Directed: empty frames vs page 0, fill, LRU eviction, end of string
  task automatic test_directed_refs();
    send_ref(16'h0000, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    for (int p = 2; p < 8; p++) send_ref(lrupr_pkg::PAGE_W'(p), 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h0008, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0003, 1'b1);
    send_ref(16'h0003, 1'b0);
    send_ref(16'hA5A5, 1'b0);
  endtask

  // Directed: frame count register at and beyond its extremes
  task automatic test_frame_settings();
    write_frames(4'd0);
    send_ref(16'h0005, 1'b0);
    send_ref(16'h0005, 1'b0);
    send_ref(16'h0006, 1'b0);
    send_ref(16'h0005, 1'b1);
    write_frames(4'd15);
    for (int p = 1; p <= 9; p++) send_ref(lrupr_pkg::PAGE_W'(p), 1'b0);
    write_frames(4'd1);
    send_ref(16'h0007, 1'b0);
    send_ref(16'h8000, 1'b0);
    write_frames(4'd9);
    send_ref(16'h5A5A, 1'b0);
    write_frames(4'd8);
    send_ref(16'h0001, 1'b0);
  endtask

  // Random strings over small working sets, one register setting per phase
  task automatic test_random_strings();
    logic [lrupr_pkg::PAGE_W-1:0] pool [12];
    int                           span;
    logic [lrupr_pkg::PAGE_W-1:0] pg;
    for (int phase = 0; phase < 6; phase++) begin
      write_frames(lrupr_pkg::CFG_W'($urandom_range(0, 15)));
      tx_gaps = (phase != 2);
      rx_gaps = (phase != 3);
      span    = $urandom_range(1, 11);
      foreach (pool[k]) pool[k] = lrupr_pkg::PAGE_W'($urandom);
      if (phase == 1) begin
        pool[0] = '0;
        pool[1] = '1;
      end
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(0, 99) < 85) pg = pool[$urandom_range(0, span)];
        else pg = lrupr_pkg::PAGE_W'($urandom);
        send_ref(pg, $urandom_range(0, 39) == 0);
        if ($urandom_range(0, 99) == 0) wait_drain();
      end
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // Receiver holds off long while the sender keeps offering
  task automatic test_backpressure();
    write_frames(4'd4);
    tx_gaps     = 1'b0;
    hold_cycles = 300;
    for (int n = 0; n < 16; n++) send_ref(lrupr_pkg::PAGE_W'($urandom_range(0, 6)), 1'b0);
    wait_drain();
    tx_gaps = 1'b1;
  endtask

  // Result receiver: random stalls per transaction, plus requested long holds
  initial begin : result_sink
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_stall_i = 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end else if (rx_gaps) begin
        n = $urandom_range(0, MAX_GAP);
        if (n != 0) begin
          out_stall_i = 1'b1;
          repeat (n) @(negedge clk_i);
        end
      end
      out_stall_i = 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    lrupr_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_item_o.fault_total, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.hit !== want.hit)
          report_mismatch("hit", out_item_o.hit, want.hit);
        if (out_item_o.frame_index !== want.frame_index)
          report_mismatch("frame_index", out_item_o.frame_index, want.frame_index);
        if (out_item_o.evicted_valid !== want.evicted_valid)
          report_mismatch("evicted_valid", out_item_o.evicted_valid, want.evicted_valid);
        if (out_item_o.evicted_page !== want.evicted_page)
          report_mismatch("evicted_page", out_item_o.evicted_page, want.evicted_page);
        if (out_item_o.fault_total !== want.fault_total)
          report_mismatch("fault_total", out_item_o.fault_total, want.fault_total);
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = lrupr_pkg::FRAMES_RST;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    frames_reg  = lrupr_pkg::FRAMES_RST;
    clear_frames();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_refs();
    test_frame_settings();
    test_backpressure();
    test_random_strings();

    wait_drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
